// ===== src/lpmd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpmd_pkg: shared types and constants of the length-prefixed message deframer
// Word formats, parser phases, result codes and the message type to class map.
// ----------------------------------------------------------------------------
package lpmd_pkg;

   // configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_BODY_LEN     = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXPECTED_VERSION = 1'd1;

   localparam logic [31:0] MAX_BODY_LEN_RESET     = 32'(50 * 1024 * 1024);
   localparam logic [15:0] EXPECTED_VERSION_RESET = 16'd1;

   // framing
   localparam logic [31:0] HEADER_BYTES = 32'd8;

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // result kinds
   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;

   // error codes
   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_TOO_LONG  = 2'd1;
   localparam logic [1:0] ERR_TOO_SHORT = 2'd2;
   localparam logic [1:0] ERR_BAD_VER   = 2'd3;

   // message classes
   localparam logic [1:0] CLASS_CMD_RESP = 2'd0;
   localparam logic [1:0] CLASS_FRAME    = 2'd1;
   localparam logic [1:0] CLASS_EVENT    = 2'd2;
   localparam logic [1:0] CLASS_UNKNOWN  = 2'd3;

   // message type codes
   localparam logic [15:0] TYPE_CMD_RESP = 16'd2;
   localparam logic [15:0] TYPE_FRAME    = 16'd3;
   localparam logic [15:0] TYPE_EVENT    = 16'd4;

   // input word functions
   localparam logic FUNC_DATA  = 1'b0;
   localparam logic FUNC_CLEAR = 1'b1;

   typedef enum logic [2:0] {
      PH_LEN,
      PH_HDR,
      PH_PAYLOAD,
      PH_SKIP,
      PH_DROP
   } phase_type;

   typedef enum logic [1:0] {
      OP_HEADER,
      OP_PAYLOAD,
      OP_ERROR
   } op_type;

   typedef struct packed {
      logic       func;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  msg_class;
      logic [31:0] request_id;
      logic [31:0] payload_len;
      logic [7:0]  payload_byte;
      logic        last;
      logic [1:0]  error_code;
   } rsp_type;

   // work item handed from front to back
   typedef struct packed {
      op_type      op;
      logic [1:0]  msg_class;
      logic [31:0] request_id;
      logic [31:0] payload_len;
      logic [7:0]  payload_byte;
      logic        last;
      logic [1:0]  error_code;
   } desc_type;

   typedef struct packed {
      logic [31:0] max_body_len;
      logic [15:0] expected_version;
   } cfg_type;

   function automatic logic [1:0] class_of(input logic [15:0] msg_type);
      logic [1:0] cls;
      cls = CLASS_UNKNOWN;
      if (msg_type == TYPE_CMD_RESP) cls = CLASS_CMD_RESP;
      else if (msg_type == TYPE_FRAME) cls = CLASS_FRAME;
      else if (msg_type == TYPE_EVENT) cls = CLASS_EVENT;
      return cls;
   endfunction

endpackage

// ===== src/lpmd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpmd_front: byte parser
// Tracks the framing phase, assembles length and header, classifies each byte.
// ----------------------------------------------------------------------------
module lpmd_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  lpmd_pkg::req_type  req,
   input  lpmd_pkg::cfg_type  cfg,
   output logic               push,
   output lpmd_pkg::desc_type desc
);

   lpmd_pkg::phase_type phase_ff, phase_in;
   logic [2:0]          cnt_ff, cnt_in;
   logic [63:0]         shift_ff, shift_in;
   logic [31:0]         plen_ff, plen_in;
   logic [31:0]         left_ff, left_in;
   logic [1:0]          cls_ff, cls_in;

   logic [31:0]         len_word;
   logic [63:0]         hdr_word;

   assign len_word = {shift_ff[23:0], req.data_byte};
   assign hdr_word = {shift_ff[55:0], req.data_byte};

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= lpmd_pkg::PH_LEN;
         cnt_ff   <= '0;
         shift_ff <= '0;
         plen_ff  <= '0;
         left_ff  <= '0;
         cls_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         shift_ff <= shift_in;
         plen_ff  <= plen_in;
         left_ff  <= left_in;
         cls_ff   <= cls_in;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      plen_in  = plen_ff;
      left_in  = left_ff;
      cls_in   = cls_ff;
      push     = 1'b0;
      desc     = '0;

      if (accept) begin
         if (req.func == lpmd_pkg::FUNC_CLEAR) begin
            phase_in = lpmd_pkg::PH_LEN;
            cnt_in   = '0;
            shift_in = '0;
            plen_in  = '0;
            left_in  = '0;
            cls_in   = '0;
         end else begin
            case (phase_ff)
               lpmd_pkg::PH_LEN: begin
                  shift_in = {32'd0, len_word};
                  cnt_in   = cnt_ff + 3'd1;
                  if (cnt_ff == 3'd3) begin
                     cnt_in   = '0;
                     shift_in = '0;
                     if (len_word > cfg.max_body_len) begin
                        phase_in        = lpmd_pkg::PH_DROP;
                        push            = 1'b1;
                        desc.op         = lpmd_pkg::OP_ERROR;
                        desc.last       = 1'b1;
                        desc.error_code = lpmd_pkg::ERR_TOO_LONG;
                     end else if (len_word < lpmd_pkg::HEADER_BYTES) begin
                        left_in         = len_word;
                        phase_in        = (len_word == '0) ? lpmd_pkg::PH_LEN
                                                           : lpmd_pkg::PH_SKIP;
                        push            = 1'b1;
                        desc.op         = lpmd_pkg::OP_ERROR;
                        desc.last       = 1'b1;
                        desc.error_code = lpmd_pkg::ERR_TOO_SHORT;
                     end else begin
                        plen_in  = len_word - lpmd_pkg::HEADER_BYTES;
                        left_in  = len_word - lpmd_pkg::HEADER_BYTES;
                        phase_in = lpmd_pkg::PH_HDR;
                     end
                  end
               end

               lpmd_pkg::PH_HDR: begin
                  shift_in = hdr_word;
                  cnt_in   = cnt_ff + 3'd1;
                  if (cnt_ff == 3'd7) begin
                     cnt_in          = '0;
                     push            = 1'b1;
                     desc.request_id = hdr_word[31:0];
                     if (hdr_word[47:32] != cfg.expected_version) begin
                        phase_in        = (left_ff == '0) ? lpmd_pkg::PH_LEN
                                                          : lpmd_pkg::PH_SKIP;
                        desc.op         = lpmd_pkg::OP_ERROR;
                        desc.last       = 1'b1;
                        desc.error_code = lpmd_pkg::ERR_BAD_VER;
                     end else begin
                        cls_in           = lpmd_pkg::class_of(hdr_word[63:48]);
                        phase_in         = (left_ff == '0) ? lpmd_pkg::PH_LEN
                                                           : lpmd_pkg::PH_PAYLOAD;
                        desc.op          = lpmd_pkg::OP_HEADER;
                        desc.msg_class   = lpmd_pkg::class_of(hdr_word[63:48]);
                        desc.payload_len = left_ff;
                        desc.last        = (left_ff == '0);
                     end
                  end
               end

               lpmd_pkg::PH_PAYLOAD: begin
                  left_in           = left_ff - 32'd1;
                  push              = 1'b1;
                  desc.op           = lpmd_pkg::OP_PAYLOAD;
                  desc.msg_class    = cls_ff;
                  desc.request_id   = shift_ff[31:0];
                  desc.payload_len  = plen_ff;
                  desc.payload_byte = req.data_byte;
                  desc.last         = (left_ff == 32'd1);
                  if (left_ff == 32'd1) begin
                     phase_in = lpmd_pkg::PH_LEN;
                     shift_in = '0;
                  end
               end

               lpmd_pkg::PH_SKIP: begin
                  if (left_ff != '0) left_in = left_ff - 32'd1;
                  if (left_ff <= 32'd1) begin
                     phase_in = lpmd_pkg::PH_LEN;
                     shift_in = '0;
                  end
               end

               default: begin
                  // dropping until the connection is cleared
               end
            endcase
         end
      end
   end

endmodule

// ===== src/lpmd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpmd_queue: small FIFO between parser and output stage
// Register-based, full flag from the registered fill count.
// ----------------------------------------------------------------------------
module lpmd_queue #(
   parameter int DEPTH = lpmd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  lpmd_pkg::desc_type push_data,
   input  logic               pop,
   output logic               full,
   output logic               not_empty,
   output lpmd_pkg::desc_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   lpmd_pkg::desc_type entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) count_in = count_ff + CNT_W'(1);
      else if (do_pop && !do_push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

// ===== src/lpmd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpmd_back: result formatter and output register
// Turns a queued work item into a result word and holds it while stalled.
// ----------------------------------------------------------------------------
module lpmd_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  lpmd_pkg::desc_type q_data,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output lpmd_pkg::rsp_type  rsp_data
);

   logic              valid_ff, valid_in;
   lpmd_pkg::rsp_type data_ff, data_in;
   logic              load;

   assign load = !valid_ff || !rsp_stall;
   assign pop  = q_valid && load;

   always_comb begin
      valid_in = load ? q_valid : valid_ff;
      data_in  = '0;
      case (q_data.op)
         lpmd_pkg::OP_HEADER: begin
            data_in.kind        = lpmd_pkg::KIND_HEADER;
            data_in.msg_class   = q_data.msg_class;
            data_in.request_id  = q_data.request_id;
            data_in.payload_len = q_data.payload_len;
            data_in.last        = q_data.last;
         end
         lpmd_pkg::OP_PAYLOAD: begin
            data_in.kind         = lpmd_pkg::KIND_PAYLOAD;
            data_in.msg_class    = q_data.msg_class;
            data_in.request_id   = q_data.request_id;
            data_in.payload_len  = q_data.payload_len;
            data_in.payload_byte = q_data.payload_byte;
            data_in.last         = q_data.last;
         end
         lpmd_pkg::OP_ERROR: begin
            data_in.kind       = lpmd_pkg::KIND_ERROR;
            data_in.request_id = q_data.request_id;
            data_in.last       = q_data.last;
            data_in.error_code = q_data.error_code;
         end
         default: begin
            data_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (pop) data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// ===== src/length_prefixed_message_deframer.sv =====
`timescale 1ns / 1ps
// A result word passes through the queue and then the output register before it
// can be taken. Throughput: one input word per cycle while req_stall is low.
// req_stall rises only when the parser-to-output queue is full.
// Reset (synchronous, active high) returns the parser to the length phase,
// empties the queue and loads max_body_len 52428800 and expected_version 1.
// ----------------------------------------------------------------------------
// length_prefixed_message_deframer: byte stream to message deframer
// Splits a stream of length-prefixed messages into header, payload and error
// result words.
// ----------------------------------------------------------------------------
module length_prefixed_message_deframer #(
   parameter int QUEUE_DEPTH = lpmd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,

   // input words: data bytes and connection-clear events
   input  logic                                req_valid,
   output logic                                req_stall,
   input  lpmd_pkg::req_type                   req_data,

   // result words
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output lpmd_pkg::rsp_type                   rsp_data,

   // register writes
   input  logic                                csr_write_en,
   input  logic [lpmd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lpmd_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   // Configuration registers. The user must make writes only while the block is idle;
   // the block does not enforce this, and the parser uses them directly.
   lpmd_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            lpmd_pkg::CSR_MAX_BODY_LEN:     cfg_in.max_body_len     = csr_wdata;
            lpmd_pkg::CSR_EXPECTED_VERSION: cfg_in.expected_version = csr_wdata[15:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_body_len     <= lpmd_pkg::MAX_BODY_LEN_RESET;
         cfg_ff.expected_version <= lpmd_pkg::EXPECTED_VERSION_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: parser. Each accepted word advances it, save data words in the drop
   // phase; at most one work item comes out per word.
   logic               accept;
   logic               q_full;
   logic               front_push;
   lpmd_pkg::desc_type front_desc;

   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;

   lpmd_front u_front (
      .clock (clock),
      .reset (reset),
      .accept(accept),
      .req   (req_data),
      .cfg   (cfg_ff),
      .push  (front_push),
      .desc  (front_desc)
   );

   // Queue: absorbs output back-pressure so the parser keeps taking bytes
   // until it fills.
   logic               q_not_empty;
   logic               back_pop;
   lpmd_pkg::desc_type q_head;

   lpmd_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (front_push),
      .push_data(front_desc),
      .pop      (back_pop),
      .full     (q_full),
      .not_empty(q_not_empty),
      .head     (q_head)
   );

   // Back: formats the item, zeroes unused fields, holds it in the output
   // register until taken.
   lpmd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_not_empty),
      .q_data   (q_head),
      .pop      (back_pop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

endmodule
